// ===== rtl/lcg_pkg.sv =====
package lcg_pkg;

	localparam int UNITS_DEF = 256;
	localparam int DW = 16;
	localparam int TAB_PTS = 257;
	localparam logic signed [17:0] Q_ONE = 18'sd4096;

	typedef enum logic [1:0] {
		OP_FWD        = 2'd0,
		OP_BWD_HIDDEN = 2'd1,
		OP_BWD_CELL   = 2'd2
	} op_t;

	typedef logic [TAB_PTS-1:0][DW-1:0] act_tab_t;

	typedef struct packed {
		logic signed [DW-1:0] i;
		logic signed [DW-1:0] f;
		logic signed [DW-1:0] g;
		logic signed [DW-1:0] o;
		logic signed [DW-1:0] cell_val;
	} cache_word_t;

	// shift-subtract division, elaboration only
	function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		int b;
		q = '0;
		r = '0;
		for (b = 63; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// table points at -8 + k/16, k = 0..256
	function automatic act_tab_t build_tab(input logic tanh_sel);
		act_tab_t t;
		logic [63:0] e [TAB_PTS];
		logic [63:0] den;
		logic [63:0] s;
		logic [63:0] q;
		logic [63:0] tv;
		int k;
		int m;
		e[0] = 64'h1_0000_0000;
		for (k = 1; k < TAB_PTS; k++)
			e[k] = (e[k-1] * 64'd4034748385 + 64'h8000_0000) >> 32;
		for (k = 0; k < TAB_PTS; k++) begin
			m = (k >= 128) ? k - 128 : 128 - k;
			if (!tanh_sel) begin
				den = 64'h1_0000_0000 + e[m];
				s = udiv((64'd1 << 44) + (den >> 1), den);
				t[k] = (k >= 128) ? DW'(s) : DW'(64'd4096 - s);
			end else begin
				q = e[2*m];
				den = 64'h1_0000_0000 + q;
				tv = udiv(64'd4096 * (64'h1_0000_0000 - q) + (den >> 1), den);
				t[k] = (k >= 128) ? DW'(tv) : DW'(64'd0 - tv);
			end
		end
		return t;
	endfunction

	localparam act_tab_t SIG_TAB  = build_tab(1'b0);
	localparam act_tab_t TANH_TAB = build_tab(1'b1);

	function automatic logic signed [DW-1:0] sat16(input logic signed [35:0] v);
		if (v > 36'sd32767)
			return 16'sh7fff;
		else if (v < -36'sd32768)
			return 16'sh8000;
		else
			return v[DW-1:0];
	endfunction

	// Q4.12 product, round half up, saturate
	function automatic logic signed [DW-1:0] qmul(input logic signed [17:0] a,
			input logic signed [17:0] b);
		logic signed [35:0] p;
		p = a * b;
		return sat16((p + 36'sd2048) >>> 12);
	endfunction

	// table lookup with linear interpolation over 256 segments
	function automatic logic signed [DW-1:0] act(input act_tab_t tab,
			input logic signed [DW-1:0] x);
		logic [15:0] u;
		logic [8:0] k1;
		logic signed [16:0] t0;
		logic signed [16:0] t1;
		logic signed [16:0] diff;
		logic signed [25:0] prod;
		u = x ^ 16'h8000;
		k1 = {1'b0, u[15:8]} + 9'd1;
		t0 = 17'($signed(tab[u[15:8]]));
		t1 = 17'($signed(tab[k1]));
		diff = t1 - t0;
		prod = 26'(diff) * 26'($signed({1'b0, u[7:0]}));
		prod = (prod + 26'sd128) >>> 8;
		return DW'(26'(t0) + prod);
	endfunction

endpackage

// ===== rtl/lcg_req_if.sv =====
interface lcg_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [7:0]         unit_index;
	logic signed [15:0] pre_input_gate;
	logic signed [15:0] pre_forget_gate;
	logic signed [15:0] pre_candidate;
	logic signed [15:0] pre_output_gate;
	logic signed [15:0] cell_in;
	logic signed [15:0] grad_in;

	modport source (output valid, op, unit_index, pre_input_gate, pre_forget_gate,
		pre_candidate, pre_output_gate, cell_in, grad_in, input ready);
	modport sink (input valid, op, unit_index, pre_input_gate, pre_forget_gate,
		pre_candidate, pre_output_gate, cell_in, grad_in, output ready);
endinterface

// ===== rtl/lcg_rsp_if.sv =====
interface lcg_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] hidden_out;
	logic signed [15:0] cell_out;
	logic signed [15:0] grad_input_gate;
	logic signed [15:0] grad_forget_gate;
	logic signed [15:0] grad_candidate;
	logic signed [15:0] grad_output_gate;
	logic signed [15:0] grad_prev_cell;

	modport source (output valid, hidden_out, cell_out, grad_input_gate, grad_forget_gate,
		grad_candidate, grad_output_gate, grad_prev_cell, input ready);
	modport sink (input valid, hidden_out, cell_out, grad_input_gate, grad_forget_gate,
		grad_candidate, grad_output_gate, grad_prev_cell, output ready);
endinterface

// ===== rtl/lcg_cache.sv =====
module lcg_cache #(
	parameter int UNITS = lcg_pkg::UNITS_DEF,
	parameter int AW = 8
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	input  logic [AW-1:0]        cur_addr,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  lcg_pkg::cache_word_t wr_data,
	output lcg_pkg::cache_word_t rd_word
);
	import lcg_pkg::*;

	cache_word_t mem [UNITS];
	cache_word_t rd_q;
	logic        cur_hit;

	assign cur_hit = wr_en && (wr_addr == cur_addr);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// read word snoops later writes while the request waits in stage one
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr))
				rd_q <= wr_data;
			else
				rd_q <= mem[rd_addr];
		end else if (cur_hit) begin
			rd_q <= wr_data;
		end
	end

	assign rd_word = cur_hit ? wr_data : rd_q;

endmodule

// ===== rtl/lstm_cell_gates_fwd_bwd.sv =====
// A request runs from the stage 1 register to the output register, which drives rsp.
// Throughput: one request per cycle while rsp.ready is high; forward and backward requests mix freely.
// Empty stages collapse, so a request is taken while a finished result waits.
// Reset (arst_n low) clears all stage valid bits; cache contents stay undefined
// until a forward request writes the entry.
module lstm_cell_gates_fwd_bwd #(
	parameter int UNITS = lcg_pkg::UNITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	lcg_req_if.sink   req,
	lcg_rsp_if.source rsp
);
	import lcg_pkg::*;

	localparam int AW = (UNITS > 1) ? $clog2(UNITS) : 1;
	localparam int NS = 7;

	function automatic logic [255:0][AW-1:0] build_map();
		logic [255:0][AW-1:0] m;
		int j;
		int v;
		for (j = 0; j < 256; j++) begin
			v = j;
			while (v >= UNITS)
				v = v - UNITS;
			m[j] = AW'(v);
		end
		return m;
	endfunction

	localparam logic [255:0][AW-1:0] IDX_MAP = build_map();

	logic [NS:1] v_q;
	logic [NS+1:1] en;

	assign en[NS+1] = rsp.ready;
	for (genvar k = 1; k <= NS; k++) begin : g_en
		assign en[k] = !v_q[k] || en[k+1];
	end

	assign req.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1])
				v_q[1] <= req.valid;
			for (int k = 2; k <= NS; k++)
				if (en[k])
					v_q[k] <= v_q[k-1];
		end
	end

	// stage 1
	logic [1:0]           op_s1;
	logic [AW-1:0]        idx_s1;
	logic signed [15:0]   prev_s1, d_s1, ai_s1, af_s1, ag_s1, ao_s1;
	logic [AW-1:0]        idx_in;

	assign idx_in = IDX_MAP[req.unit_index];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			op_s1   <= req.op;
			idx_s1  <= idx_in;
			prev_s1 <= req.cell_in;
			d_s1    <= req.grad_in;
			ai_s1   <= act(SIG_TAB, req.pre_input_gate);
			af_s1   <= act(SIG_TAB, req.pre_forget_gate);
			ag_s1   <= act(TANH_TAB, req.pre_candidate);
			ao_s1   <= act(SIG_TAB, req.pre_output_gate);
		end
	end

	// cache
	cache_word_t        rd_word, wr_data;
	logic               wr_en;
	logic [1:0]         op_s2;
	logic [AW-1:0]      idx_s2;
	logic signed [15:0] prev_s2, d_s2, gi_s2, gf_s2, gg_s2, go_s2, gc_s2;
	logic signed [31:0] pf_s2, pg_s2;
	logic signed [33:0] csum;
	logic signed [15:0] cell_c;

	assign csum    = 34'(pf_s2) + 34'(pg_s2) + 34'sd2048;
	assign cell_c  = sat16(36'(csum >>> 12));
	assign wr_en   = v_q[2] && (op_s2 == OP_FWD) && en[3];
	assign wr_data = '{i: gi_s2, f: gf_s2, g: gg_s2, o: go_s2, cell_val: cell_c};

	lcg_cache #(.UNITS(UNITS), .AW(AW)) u_cache (
		.clk      (clk),
		.rd_en    (req.valid && en[1]),
		.rd_addr  (idx_in),
		.cur_addr (idx_s1),
		.wr_en    (wr_en),
		.wr_addr  (idx_s2),
		.wr_data  (wr_data),
		.rd_word  (rd_word)
	);

	// stage 2: forward cell products, backward cache word
	always_ff @(posedge clk) begin
		if (en[2]) begin
			op_s2   <= op_s1;
			idx_s2  <= idx_s1;
			prev_s2 <= prev_s1;
			d_s2    <= d_s1;
			pf_s2   <= 32'(af_s1) * 32'(prev_s1);
			pg_s2   <= 32'(ai_s1) * 32'(ag_s1);
			if (op_s1 == OP_FWD) begin
				gi_s2 <= ai_s1;
				gf_s2 <= af_s1;
				gg_s2 <= ag_s1;
				go_s2 <= ao_s1;
				gc_s2 <= '0;
			end else begin
				gi_s2 <= rd_word.i;
				gf_s2 <= rd_word.f;
				gg_s2 <= rd_word.g;
				go_s2 <= rd_word.o;
				gc_s2 <= rd_word.cell_val;
			end
		end
	end

	// stage 3: cell or tanh(cached cell), first-level products
	logic [1:0]         op_s3;
	logic signed [15:0] prev_s3, d_s3, gi_s3, gf_s3, gg_s3, go_s3, c_s3;
	logic signed [15:0] a_s3, fo_s3, hi_s3, hf_s3, gsq_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			op_s3   <= op_s2;
			prev_s3 <= prev_s2;
			d_s3    <= d_s2;
			gi_s3   <= gi_s2;
			gf_s3   <= gf_s2;
			gg_s3   <= gg_s2;
			go_s3   <= go_s2;
			c_s3    <= (op_s2 == OP_FWD) ? cell_c : act(TANH_TAB, gc_s2);
			a_s3    <= qmul(18'(d_s2), 18'(go_s2));
			fo_s3   <= qmul(18'(go_s2), Q_ONE - 18'(go_s2));
			hi_s3   <= qmul(18'(gi_s2), Q_ONE - 18'(gi_s2));
			hf_s3   <= qmul(18'(gf_s2), Q_ONE - 18'(gf_s2));
			gsq_s3  <= qmul(18'(gg_s2), 18'(gg_s2));
		end
	end

	// stage 4: forward tanh(cell); backward tc*tc and d*tc
	logic [1:0]         op_s4;
	logic signed [15:0] prev_s4, d_s4, gi_s4, gf_s4, gg_s4, go_s4, cell_s4, t_s4, e_s4;
	logic signed [15:0] a_s4, fo_s4, hi_s4, hf_s4, gsq_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			op_s4   <= op_s3;
			prev_s4 <= prev_s3;
			d_s4    <= d_s3;
			gi_s4   <= gi_s3;
			gf_s4   <= gf_s3;
			gg_s4   <= gg_s3;
			go_s4   <= go_s3;
			cell_s4 <= c_s3;
			t_s4    <= (op_s3 == OP_FWD) ? act(TANH_TAB, c_s3) : qmul(18'(c_s3), 18'(c_s3));
			e_s4    <= qmul(18'(d_s3), 18'(c_s3));
			a_s4    <= a_s3;
			fo_s4   <= fo_s3;
			hi_s4   <= hi_s3;
			hf_s4   <= hf_s3;
			gsq_s4  <= gsq_s3;
		end
	end

	// stage 5: hidden value, cell gradient, output gate gradient
	logic [1:0]         op_s5;
	logic signed [15:0] prev_s5, gi_s5, gf_s5, gg_s5, hid_s5, cell_s5, dc_s5, go5_s5;
	logic signed [15:0] hi_s5, hf_s5, gsq_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			op_s5   <= op_s4;
			prev_s5 <= prev_s4;
			gi_s5   <= gi_s4;
			gf_s5   <= gf_s4;
			gg_s5   <= gg_s4;
			hid_s5  <= qmul(18'(go_s4), 18'(t_s4));
			cell_s5 <= cell_s4;
			if (op_s4 == OP_BWD_HIDDEN) begin
				dc_s5  <= qmul(18'(a_s4), Q_ONE - 18'(t_s4));
				go5_s5 <= qmul(18'(e_s4), 18'(fo_s4));
			end else begin
				dc_s5  <= d_s4;
				go5_s5 <= '0;
			end
			hi_s5   <= hi_s4;
			hf_s5   <= hf_s4;
			gsq_s5  <= gsq_s4;
		end
	end

	// stage 6: products with the cell gradient
	logic [1:0]         op_s6;
	logic signed [15:0] hid_s6, cell_s6, go5_s6, p1_s6, p2_s6, p3_s6, gpc_s6;
	logic signed [15:0] hi_s6, hf_s6, gsq_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			op_s6   <= op_s5;
			hid_s6  <= hid_s5;
			cell_s6 <= cell_s5;
			go5_s6  <= go5_s5;
			p1_s6   <= qmul(18'(dc_s5), 18'(gg_s5));
			p2_s6   <= qmul(18'(dc_s5), 18'(prev_s5));
			p3_s6   <= qmul(18'(dc_s5), 18'(gi_s5));
			gpc_s6  <= qmul(18'(dc_s5), 18'(gf_s5));
			hi_s6   <= hi_s5;
			hf_s6   <= hf_s5;
			gsq_s6  <= gsq_s5;
		end
	end

	// stage 7: output register
	logic signed [15:0] hid_s7, cell_s7, gig_s7, gfg_s7, gcd_s7, gog_s7, gpc_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			case (op_s6)
				OP_FWD: begin
					hid_s7  <= hid_s6;
					cell_s7 <= cell_s6;
					gig_s7  <= '0;
					gfg_s7  <= '0;
					gcd_s7  <= '0;
					gog_s7  <= '0;
					gpc_s7  <= '0;
				end
				OP_BWD_HIDDEN, OP_BWD_CELL: begin
					hid_s7  <= '0;
					cell_s7 <= '0;
					gig_s7  <= qmul(18'(p1_s6), 18'(hi_s6));
					gfg_s7  <= qmul(18'(p2_s6), 18'(hf_s6));
					gcd_s7  <= qmul(18'(p3_s6), Q_ONE - 18'(gsq_s6));
					gog_s7  <= go5_s6;
					gpc_s7  <= gpc_s6;
				end
				default: begin
					hid_s7  <= '0;
					cell_s7 <= '0;
					gig_s7  <= '0;
					gfg_s7  <= '0;
					gcd_s7  <= '0;
					gog_s7  <= '0;
					gpc_s7  <= '0;
				end
			endcase
		end
	end

	assign rsp.valid            = v_q[NS];
	assign rsp.hidden_out       = hid_s7;
	assign rsp.cell_out         = cell_s7;
	assign rsp.grad_input_gate  = gig_s7;
	assign rsp.grad_forget_gate = gfg_s7;
	assign rsp.grad_candidate   = gcd_s7;
	assign rsp.grad_output_gate = gog_s7;
	assign rsp.grad_prev_cell   = gpc_s7;

endmodule

// ===== sim/lcg_tb_if.sv =====
`timescale 1ns / 1ps
// Bench-side types. The RTL interfaces in rtl/ are used
// directly, so this file only holds the shared request and result types.
package lcg_tb_types;
	import lcg_pkg::*;

	typedef struct {
		logic [1:0]         op;
		logic [7:0]         unit_index;
		logic signed [15:0] pi;
		logic signed [15:0] pf;
		logic signed [15:0] pg;
		logic signed [15:0] po;
		logic signed [15:0] prev;
		logic signed [15:0] grad;
	} gate_req_t;

	typedef struct {
		logic signed [15:0] hidden;
		logic signed [15:0] cell_val;
		logic signed [15:0] gi;
		logic signed [15:0] gf;
		logic signed [15:0] gg;
		logic signed [15:0] go;
		logic signed [15:0] gp;
	} gate_rsp_t;
endpackage

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import lcg_pkg::*;
	import lcg_tb_types::*;

	localparam int WATCHDOG = 20000;
	localparam int N_RANDOM = 1700;
	localparam logic [1:0] OP_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lcg_req_if req ();
	lcg_rsp_if rsp ();

	lstm_cell_gates_fwd_bwd u_top (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int sig_pts [257];
	int tanh_pts [257];
	int c_i [256];
	int c_f [256];
	int c_g [256];
	int c_o [256];
	int c_cell [256];
	bit written [256];

	gate_rsp_t pending_rsp [$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_rsp = 1'b0;
	bit stim_done = 1'b0;

	function automatic longint round_div(longint n, longint d);
		return (n + d / 2) / d;
	endfunction

	function automatic void build_points();
		longint unsigned e [257];
		longint unsigned den;
		longint s;
		longint t;
		int m;
		e[0] = 64'h1_0000_0000;
		for (int k = 1; k <= 256; k++)
			e[k] = (e[k-1] * 64'd4034748385 + 64'h8000_0000) >> 32;
		for (int k = 0; k <= 256; k++) begin
			m = (k >= 128) ? k - 128 : 128 - k;
			den = 64'h1_0000_0000 + e[m];
			s = ((64'd1 << 44) + den / 2) / den;
			den = 64'h1_0000_0000 + e[2*m];
			t = (64'd4096 * (64'h1_0000_0000 - e[2*m]) + den / 2) / den;
			sig_pts[k] = (k >= 128) ? int'(s) : 4096 - int'(s);
			tanh_pts[k] = (k >= 128) ? int'(t) : -int'(t);
		end
	endfunction

	function automatic int clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return int'(v);
	endfunction

	// floor((p + 2048) / 4096)
	function automatic longint q12_round(longint p);
		return (p + 2048) >>> 12;
	endfunction

	function automatic int qm(int a, int b);
		return clamp16(q12_round(longint'(a) * longint'(b)));
	endfunction

	function automatic int interp(bit use_tanh, int x);
		int u;
		int k;
		int fr;
		int t0;
		int t1;
		u = (x + 32768) & 16'hffff;
		k = u >> 8;
		fr = u & 255;
		t0 = use_tanh ? tanh_pts[k] : sig_pts[k];
		t1 = use_tanh ? tanh_pts[k+1] : sig_pts[k+1];
		return t0 + (((t1 - t0) * fr + 128) >>> 8);
	endfunction

	function automatic gate_rsp_t predict_gates(gate_req_t r);
		gate_rsp_t y;
		int ig;
		int fg;
		int gg;
		int og;
		int cl;
		int tc;
		int dc;
		int j;
		y = '{default: '0};
		j = r.unit_index;
		if (r.op == OP_FWD) begin
			ig = interp(0, r.pi);
			fg = interp(0, r.pf);
			gg = interp(1, r.pg);
			og = interp(0, r.po);
			cl = clamp16(q12_round(longint'(fg) * r.prev + longint'(ig) * gg));
			y.hidden = qm(og, interp(1, cl));
			y.cell_val = cl;
			c_i[j] = ig;
			c_f[j] = fg;
			c_g[j] = gg;
			c_o[j] = og;
			c_cell[j] = cl;
			written[j] = 1'b1;
		end else if (r.op == OP_BWD_HIDDEN || r.op == OP_BWD_CELL) begin
			ig = c_i[j];
			fg = c_f[j];
			gg = c_g[j];
			og = c_o[j];
			if (r.op == OP_BWD_HIDDEN) begin
				tc = interp(1, c_cell[j]);
				dc = qm(qm(r.grad, og), 4096 - qm(tc, tc));
				y.go = qm(qm(r.grad, tc), qm(og, 4096 - og));
			end else begin
				dc = r.grad;
			end
			y.gi = qm(qm(dc, gg), qm(ig, 4096 - ig));
			y.gf = qm(qm(dc, r.prev), qm(fg, 4096 - fg));
			y.gg = qm(qm(dc, ig), 4096 - qm(gg, gg));
			y.gp = qm(dc, fg);
		end
		return y;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic gate_req_t rand_req(bit bwd_ok);
		gate_req_t r;
		int sel;
		r.unit_index = 8'($urandom_range(0, 15)) | (($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0);
		r.pi = 16'($urandom);
		r.pf = 16'($urandom);
		r.pg = 16'($urandom);
		r.po = 16'($urandom);
		r.prev = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($signed(16'($urandom_range(0, 16383))) - 16'sd8192);
		r.grad = 16'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 4) r.op = OP_NONE;
		else if (sel < 45 || !bwd_ok || !written[r.unit_index]) r.op = OP_FWD;
		else if (sel < 75) r.op = OP_BWD_HIDDEN;
		else r.op = OP_BWD_CELL;
		if (r.op != OP_FWD && r.op != OP_NONE && !written[r.unit_index]) r.op = OP_FWD;
		return r;
	endfunction

	// drive one request and wait for its acceptance
	task automatic send_req(gate_req_t r);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.op <= r.op;
		req.unit_index <= r.unit_index;
		req.pre_input_gate <= r.pi;
		req.pre_forget_gate <= r.pf;
		req.pre_candidate <= r.pg;
		req.pre_output_gate <= r.po;
		req.cell_in <= r.prev;
		req.grad_in <= r.grad;
		do @(posedge clk); while (!req.ready);
		pending_rsp.push_back(predict_gates(r));
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(negedge clk);
	endtask

	// directed rows: ops, extremes of every field, unused selector
	typedef struct {
		gate_req_t r;
		bit        has_exp;
		gate_rsp_t e;
	} dir_row_t;

	dir_row_t dir_rows [$];

	function automatic void add_row(logic [1:0] op, logic [7:0] j, int pi, int pf, int pg,
			int po, int prev, int grad, bit has_exp = 0, gate_rsp_t e = '{default: '0});
		dir_row_t d;
		d.r = '{op, j, 16'(pi), 16'(pf), 16'(pg), 16'(po), 16'(prev), 16'(grad)};
		d.has_exp = has_exp;
		d.e = e;
		dir_rows.push_back(d);
	endfunction

	initial begin
		gate_rsp_t zero_rsp;
		zero_rsp = '{default: '0};
		req.valid = 1'b0;
		req.op = '0;
		req.unit_index = '0;
		req.pre_input_gate = '0;
		req.pre_forget_gate = '0;
		req.pre_candidate = '0;
		req.pre_output_gate = '0;
		req.cell_in = '0;
		req.grad_in = '0;
		rsp.ready = 1'b0;
		build_points();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		add_row(OP_NONE, 8'd0, 32767, 32767, 32767, 32767, 32767, 32767, 1, zero_rsp);
		add_row(OP_FWD, 8'd0, 0, 0, 0, 0, 0, 0);
		add_row(OP_FWD, 8'd255, 32767, 32767, 32767, 32767, 32767, 0);
		add_row(OP_FWD, 8'd1, -32768, -32768, -32768, -32768, -32768, 0);
		add_row(OP_FWD, 8'd2, 32767, 32767, -32768, 32767, -32768, 0);
		add_row(OP_FWD, 8'd3, 4096, -4096, 2048, 12000, 20000, 0);
		add_row(OP_BWD_HIDDEN, 8'd255, 0, 0, 0, 0, 32767, 32767);
		add_row(OP_BWD_HIDDEN, 8'd1, -1, -1, -1, -1, -32768, -32768);
		add_row(OP_BWD_CELL, 8'd2, 0, 0, 0, 0, 32767, -32768);
		add_row(OP_BWD_CELL, 8'd3, 0, 0, 0, 0, -32768, 32767);
		add_row(OP_BWD_HIDDEN, 8'd0, 0, 0, 0, 0, 0, 0, 1, zero_rsp);
		add_row(OP_BWD_CELL, 8'd0, 0, 0, 0, 0, 0, 0, 1, zero_rsp);
		add_row(OP_NONE, 8'd3, -1, -1, -1, -1, -1, -1, 1, zero_rsp);
		add_row(OP_BWD_CELL, 8'd3, 0, 0, 0, 0, 1234, 5678);

		foreach (dir_rows[n]) begin
			send_req(dir_rows[n].r);
			if (dir_rows[n].has_exp) begin
				void'(pending_rsp.pop_back());
				pending_rsp.push_back(dir_rows[n].e);
			end
		end
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 60 : 0;
			recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 26 : 0;
			for (int n = 0; n < N_RANDOM / 3; n++) begin
				if (n == 100) drain();
				if (n == 200) hold_rsp = 1'b1;
				send_req(rand_req(1));
			end
		end
		drain();
		repeat (20) @(negedge clk);
		stim_done = 1'b1;
	end

	// receiver: random stall plus a long hold-off in each random phase
	initial begin
		int hold_cnt;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				hold_cnt = 0;
				rsp.ready <= 1'b0;
				while (hold_cnt < 60) begin
					@(negedge clk);
					hold_cnt++;
				end
				hold_rsp = 1'b0;
			end
			rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		gate_rsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				$display("unexpected result at %0t", $realtime);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.hidden_out !== e.hidden) report_mismatch("hidden_out", rsp.hidden_out, e.hidden);
				if (rsp.cell_out !== e.cell_val) report_mismatch("cell_out", rsp.cell_out, e.cell_val);
				if (rsp.grad_input_gate !== e.gi)
					report_mismatch("grad_input_gate", rsp.grad_input_gate, e.gi);
				if (rsp.grad_forget_gate !== e.gf)
					report_mismatch("grad_forget_gate", rsp.grad_forget_gate, e.gf);
				if (rsp.grad_candidate !== e.gg)
					report_mismatch("grad_candidate", rsp.grad_candidate, e.gg);
				if (rsp.grad_output_gate !== e.go)
					report_mismatch("grad_output_gate", rsp.grad_output_gate, e.go);
				if (rsp.grad_prev_cell !== e.gp)
					report_mismatch("grad_prev_cell", rsp.grad_prev_cell, e.gp);
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stim_done) begin
				if (errors == 0 && pending_rsp.size() == 0)
					$display("PASS lstm_cell_gates_fwd_bwd");
				else
					$display("FAIL lstm_cell_gates_fwd_bwd");
				$finish;
			end else if (idle_cycles >= WATCHDOG) begin
				$display("FAIL lstm_cell_gates_fwd_bwd");
				$finish;
			end
		end
	end
endmodule

// ===== filelist.f =====
rtl/lcg_pkg.sv
rtl/lcg_req_if.sv
rtl/lcg_rsp_if.sv
rtl/lcg_cache.sv
rtl/lstm_cell_gates_fwd_bwd.sv
sim/lcg_tb_if.sv
sim/tb.sv
